// ===== src/tds_pkg.sv =====
// Shared types, codes and default sizes of the task dependency scheduler.
// No dependencies; every other file imports this package.
`default_nettype none
package tds_pkg;

   localparam int DEF_MAX_TASKS      = 64;
   localparam int DEF_MAX_DEPS       = 4;
   localparam int DEF_MAX_DEPENDENTS = 8;
   localparam int DEF_PAYLOAD_WIDTH  = 32;

   localparam int DEP_SLOTS = 4;
   localparam int COUNT_W   = 3;
   localparam int PEND_W    = 3;

   typedef enum logic [1:0] {
      OP_SUBMIT   = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_INVALID  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED   = 3'd0,
      ST_DISPATCHED = 3'd1,
      ST_WAIT       = 3'd2,
      ST_ALL_DONE   = 3'd3,
      ST_TABLE_FULL = 3'd4,
      ST_DEPS_FULL  = 3'd5,
      ST_BAD_DEP    = 3'd6
   } status_type;

   typedef struct packed {
      op_type op;
      logic   dep_bad;
   } cmd_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SUB_CHK,
      S_SUB_WR,
      S_SUB_LINK,
      S_DSP_RD,
      S_DSP_ID,
      S_DSP_PAY,
      S_CPL_CNT,
      S_CPL_PND,
      S_CPL_UPD,
      S_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== src/tds_front.sv =====
// Front end: accepts request beats, classifies them and holds them in a two-entry queue.
// Depends on tds_pkg.
`default_nettype none
module tds_front #(
   parameter int MAX_TASKS     = 64,
   parameter int MAX_DEPS      = 4,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_type,
   input  wire logic [PAYLOAD_WIDTH-1:0]         req_task_payload,
   input  wire logic [tds_pkg::COUNT_W-1:0]      req_dep_count,
   input  wire logic [$clog2(MAX_TASKS)-1:0]     req_dep_task_0,
   input  wire logic [$clog2(MAX_TASKS)-1:0]     req_dep_task_1,
   input  wire logic [$clog2(MAX_TASKS)-1:0]     req_dep_task_2,
   input  wire logic [$clog2(MAX_TASKS)-1:0]     req_dep_task_3,
   input  wire logic [$clog2(MAX_TASKS)-1:0]     req_done_task_id,
   output logic                                  cmd_valid,
   input  wire logic                             cmd_pop,
   output tds_pkg::cmd_ctl_type                  cmd_ctl,
   output logic [PAYLOAD_WIDTH-1:0]              cmd_payload,
   output logic [tds_pkg::COUNT_W-1:0]           cmd_count,
   output logic [$clog2(MAX_TASKS)-1:0]          cmd_dep [tds_pkg::DEP_SLOTS],
   output logic [$clog2(MAX_TASKS)-1:0]          cmd_done
);
   import tds_pkg::*;

   localparam int ID_W = $clog2(MAX_TASKS);

   cmd_ctl_type            ctl_q_ff   [2];
   logic [PAYLOAD_WIDTH-1:0] pay_q_ff [2];
   logic [COUNT_W-1:0]     cnt_q_ff   [2];
   logic [ID_W-1:0]        dep_q_ff   [2][DEP_SLOTS];
   logic [ID_W-1:0]        done_q_ff  [2];
   logic [1:0]             fill_ff, fill_in;
   logic                   wp_ff, wp_in, rp_ff, rp_in;
   cmd_ctl_type            ctl_new;
   logic                   push;

   always_comb begin
      unique case (req_type)
         OP_SUBMIT:   ctl_new.op = OP_SUBMIT;
         OP_DISPATCH: ctl_new.op = OP_DISPATCH;
         OP_COMPLETE: ctl_new.op = OP_COMPLETE;
         default:     ctl_new.op = OP_INVALID;
      endcase
      ctl_new.dep_bad = (req_dep_count > COUNT_W'(DEP_SLOTS)) ||
                        ({1'b0, req_dep_count} > (COUNT_W+1)'(MAX_DEPS));
   end

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != 2'd0);

   always_comb begin
      fill_in = fill_ff + 2'(push) - 2'(cmd_pop);
      wp_in   = push ? ~wp_ff : wp_ff;
      rp_in   = cmd_pop ? ~rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_q_ff[wp_ff]    <= ctl_new;
         pay_q_ff[wp_ff]    <= req_task_payload;
         cnt_q_ff[wp_ff]    <= req_dep_count;
         dep_q_ff[wp_ff][0] <= req_dep_task_0;
         dep_q_ff[wp_ff][1] <= req_dep_task_1;
         dep_q_ff[wp_ff][2] <= req_dep_task_2;
         dep_q_ff[wp_ff][3] <= req_dep_task_3;
         done_q_ff[wp_ff]   <= req_done_task_id;
      end
   end

   assign cmd_ctl     = ctl_q_ff[rp_ff];
   assign cmd_payload = pay_q_ff[rp_ff];
   assign cmd_count   = cnt_q_ff[rp_ff];
   assign cmd_dep     = dep_q_ff[rp_ff];
   assign cmd_done    = done_q_ff[rp_ff];

endmodule
`default_nettype wire

// ===== src/tds_engine.sv =====
// Back end: sequencer that carries out submits, dispatches and completions on the task tables.
// Depends on tds_pkg; holds the task, dependent and wave memories.
`default_nettype none
module tds_engine #(
   parameter int MAX_TASKS      = 64,
   parameter int MAX_DEPENDENTS = 8,
   parameter int PAYLOAD_WIDTH  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                cmd_valid,
   output logic                                     cmd_pop,
   input  wire tds_pkg::cmd_ctl_type                cmd_ctl,
   input  wire logic [PAYLOAD_WIDTH-1:0]            cmd_payload,
   input  wire logic [tds_pkg::COUNT_W-1:0]         cmd_count,
   input  wire logic [$clog2(MAX_TASKS)-1:0]        cmd_dep [tds_pkg::DEP_SLOTS],
   input  wire logic [$clog2(MAX_TASKS)-1:0]        cmd_done,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [2:0]                               rsp_status,
   output logic [$clog2(MAX_TASKS)-1:0]             rsp_task_id,
   output logic [PAYLOAD_WIDTH-1:0]                 rsp_out_payload,
   output logic                                     rsp_went_ready,
   output logic [$clog2(MAX_DEPENDENTS+1)-1:0]      rsp_newly_ready
);
   import tds_pkg::*;

   localparam int ID_W  = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS+1);
   localparam int DW    = $clog2(MAX_DEPENDENTS+1);
   localparam int LA_W  = $clog2(MAX_TASKS*MAX_DEPENDENTS);
   localparam int WA_W  = ID_W + 1;

   // Task tables and the two wave banks.
   logic [PAYLOAD_WIDTH-1:0] pay_mem  [MAX_TASKS];
   logic [PEND_W-1:0]        pend_mem [MAX_TASKS];
   logic [DW-1:0]            dt_mem   [MAX_TASKS];
   logic [ID_W-1:0]          list_mem [MAX_TASKS*MAX_DEPENDENTS];
   logic [ID_W-1:0]          wave_mem [2**WA_W];

   logic                     pay_we, pend_we, dt_we, list_we, wave_we;
   logic [ID_W-1:0]          pay_wa, pend_wa, dt_wa, pay_ra, pend_ra, dt_ra;
   logic [LA_W-1:0]          list_wa, list_ra;
   logic [WA_W-1:0]          wave_wa, wave_ra;
   logic [PAYLOAD_WIDTH-1:0] pay_wd, pay_rd;
   logic [PEND_W-1:0]        pend_wd, pend_rd;
   logic [DW-1:0]            dt_wd, dt_rd;
   logic [ID_W-1:0]          list_wd, list_rd, wave_wd, wave_rd;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic                     dep_bad_ff, dep_bad_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic [COUNT_W-1:0]       n_ff, n_in;
   logic [ID_W-1:0]          dep_ff [DEP_SLOTS];
   logic [ID_W-1:0]          dep_in [DEP_SLOTS];
   logic [ID_W-1:0]          done_ff, done_in;
   logic [CNT_W-1:0]         tt_ff, tt_in, rtot_ff, rtot_in, ptr_ff, ptr_in;
   logic [CNT_W-1:0]         ntot_ff, ntot_in, outs_ff, outs_in;
   logic                     bank_ff, bank_in;
   logic [1:0]               di_ff, di_in;
   logic [DW-1:0]            li_ff, li_in, cnt_ff, cnt_in;
   logic [DW-1:0]            tot_ff [DEP_SLOTS];
   logic [DW-1:0]            tot_in [DEP_SLOTS];
   logic [ID_W-1:0]          dsel_ff, dsel_in;
   status_type               res_st_ff, res_st_in;
   logic [ID_W-1:0]          res_id_ff, res_id_in;
   logic [PAYLOAD_WIDTH-1:0] res_pay_ff, res_pay_in;
   logic                     res_went_ff, res_went_in;
   logic [DW-1:0]            res_new_ff, res_new_in;
   logic                     rsp_valid_ff, rsp_load;
   logic [2:0]               rsp_status_ff;
   logic [ID_W-1:0]          rsp_id_ff;
   logic [PAYLOAD_WIDTH-1:0] rsp_pay_ff;
   logic                     rsp_went_ff;
   logic [DW-1:0]            rsp_new_ff;

   logic [2:0]               extra [DEP_SLOTS];
   logic                     range_bad;
   logic [DW+2:0]            chk_sum;
   logic [DW-1:0]            link_total;
   logic [ID_W-1:0]          new_id;

   always_ff @(posedge clock) begin
      if (pay_we) pay_mem[pay_wa] <= pay_wd;
      pay_rd <= pay_mem[pay_ra];
   end
   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[pend_wa] <= pend_wd;
      pend_rd <= pend_mem[pend_ra];
   end
   always_ff @(posedge clock) begin
      if (dt_we) dt_mem[dt_wa] <= dt_wd;
      dt_rd <= dt_mem[dt_ra];
   end
   always_ff @(posedge clock) begin
      if (list_we) list_mem[list_wa] <= list_wd;
      list_rd <= list_mem[list_ra];
   end
   always_ff @(posedge clock) begin
      if (wave_we) wave_mem[wave_wa] <= wave_wd;
      wave_rd <= wave_mem[wave_ra];
   end

   // A prerequisite named more than once takes one more dependent slot per repeat.
   always_comb begin
      range_bad = 1'b0;
      for (int i = 0; i < DEP_SLOTS; i++) begin
         extra[i] = 3'd1;
         for (int j = 0; j < DEP_SLOTS; j++) begin
            if (j < i && dep_ff[j] == dep_ff[i]) extra[i] = extra[i] + 3'd1;
         end
         if (i < int'(n_ff) && CNT_W'(dep_ff[i]) >= tt_ff) range_bad = 1'b1;
      end
   end

   assign chk_sum    = (DW+3)'(dt_rd) + (DW+3)'(extra[di_ff]);
   assign link_total = tot_ff[di_ff] + DW'(extra[di_ff]);
   assign new_id     = tt_ff[ID_W-1:0];
   assign rsp_load   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      dep_bad_in  = dep_bad_ff;
      pay_in      = pay_ff;
      n_in        = n_ff;
      dep_in      = dep_ff;
      done_in     = done_ff;
      tt_in       = tt_ff;
      rtot_in     = rtot_ff;
      ptr_in      = ptr_ff;
      ntot_in     = ntot_ff;
      outs_in     = outs_ff;
      bank_in     = bank_ff;
      di_in       = di_ff;
      li_in       = li_ff;
      cnt_in      = cnt_ff;
      tot_in      = tot_ff;
      dsel_in     = dsel_ff;
      res_st_in   = res_st_ff;
      res_id_in   = res_id_ff;
      res_pay_in  = res_pay_ff;
      res_went_in = res_went_ff;
      res_new_in  = res_new_ff;
      cmd_pop     = 1'b0;
      pay_we  = 1'b0; pay_wa  = new_id;  pay_wd  = pay_ff;  pay_ra  = wave_rd;
      pend_we = 1'b0; pend_wa = new_id;  pend_wd = PEND_W'(n_ff); pend_ra = list_rd;
      dt_we   = 1'b0; dt_wa   = new_id;  dt_wd   = '0;      dt_ra   = dep_ff[0];
      list_we = 1'b0; list_wa = '0;      list_wd = new_id;  list_ra = '0;
      wave_we = 1'b0; wave_wa = '0;      wave_wd = new_id;
      wave_ra = {bank_ff, ptr_ff[ID_W-1:0]};

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               op_in      = cmd_ctl.op;
               dep_bad_in = cmd_ctl.dep_bad;
               pay_in     = cmd_payload;
               n_in       = cmd_count;
               dep_in     = cmd_dep;
               done_in    = cmd_done;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            res_st_in   = ST_ACCEPTED;
            res_id_in   = '0;
            res_pay_in  = '0;
            res_went_in = 1'b0;
            res_new_in  = '0;
            state_in    = S_EMIT;
            unique case (op_ff)
               OP_SUBMIT: begin
                  if (tt_ff >= CNT_W'(MAX_TASKS)) begin
                     res_st_in = ST_TABLE_FULL;
                  end else if (dep_bad_ff || range_bad) begin
                     res_st_in = ST_BAD_DEP;
                  end else if (n_ff == '0) begin
                     state_in = S_SUB_WR;
                  end else begin
                     di_in    = 2'd0;
                     dt_ra    = dep_ff[0];
                     state_in = S_SUB_CHK;
                  end
               end
               OP_DISPATCH: begin
                  if (ptr_ff >= rtot_ff) begin
                     if (outs_ff != '0) begin
                        res_st_in = ST_WAIT;
                     end else if (ntot_ff == '0) begin
                        res_st_in = ST_ALL_DONE;
                        tt_in     = '0;
                        rtot_in   = '0;
                        ptr_in    = '0;
                        ntot_in   = '0;
                        outs_in   = '0;
                     end else begin
                        bank_in  = ~bank_ff;
                        rtot_in  = ntot_ff;
                        ptr_in   = '0;
                        ntot_in  = '0;
                        state_in = S_DSP_RD;
                     end
                  end else begin
                     state_in = S_DSP_RD;
                  end
               end
               OP_COMPLETE: begin
                  if (outs_ff == '0 || CNT_W'(done_ff) >= tt_ff) begin
                     res_st_in = ST_BAD_DEP;
                  end else begin
                     outs_in  = outs_ff - 1'b1;
                     dt_ra    = done_ff;
                     state_in = S_CPL_CNT;
                  end
               end
               default: res_st_in = ST_BAD_DEP;
            endcase
         end
         S_SUB_CHK: begin
            if (chk_sum > (DW+3)'(MAX_DEPENDENTS)) begin
               res_st_in = ST_DEPS_FULL;
               state_in  = S_EMIT;
            end else begin
               tot_in[di_ff] = dt_rd;
               if ({1'b0, di_ff} == n_ff - 3'd1) begin
                  state_in = S_SUB_WR;
               end else begin
                  di_in = di_ff + 2'd1;
                  dt_ra = dep_ff[di_ff + 2'd1];
               end
            end
         end
         S_SUB_WR: begin
            pay_we  = 1'b1;
            pend_we = 1'b1;
            dt_we   = 1'b1;
            res_id_in = new_id;
            if (n_ff == '0) begin
               if (rtot_ff < CNT_W'(MAX_TASKS)) begin
                  wave_we     = 1'b1;
                  wave_wa     = {bank_ff, rtot_ff[ID_W-1:0]};
                  rtot_in     = rtot_ff + 1'b1;
                  res_went_in = 1'b1;
               end
               tt_in    = tt_ff + 1'b1;
               state_in = S_EMIT;
            end else begin
               di_in    = 2'd0;
               state_in = S_SUB_LINK;
            end
         end
         S_SUB_LINK: begin
            list_we = 1'b1;
            list_wa = LA_W'(dep_ff[di_ff]) * LA_W'(MAX_DEPENDENTS) + LA_W'(link_total - 1'b1);
            dt_we   = 1'b1;
            dt_wa   = dep_ff[di_ff];
            dt_wd   = link_total;
            if ({1'b0, di_ff} == n_ff - 3'd1) begin
               tt_in    = tt_ff + 1'b1;
               state_in = S_EMIT;
            end else begin
               di_in = di_ff + 2'd1;
            end
         end
         S_DSP_RD: begin
            wave_ra  = {bank_ff, ptr_ff[ID_W-1:0]};
            state_in = S_DSP_ID;
         end
         S_DSP_ID: begin
            res_id_in = wave_rd;
            pay_ra    = wave_rd;
            state_in  = S_DSP_PAY;
         end
         S_DSP_PAY: begin
            res_st_in  = ST_DISPATCHED;
            res_pay_in = pay_rd;
            ptr_in     = ptr_ff + 1'b1;
            outs_in    = outs_ff + 1'b1;
            state_in   = S_EMIT;
         end
         S_CPL_CNT: begin
            cnt_in    = dt_rd;
            li_in     = '0;
            res_id_in = done_ff;
            list_ra   = LA_W'(done_ff) * LA_W'(MAX_DEPENDENTS);
            state_in  = (dt_rd == '0) ? S_EMIT : S_CPL_PND;
         end
         S_CPL_PND: begin
            dsel_in  = list_rd;
            pend_ra  = list_rd;
            state_in = S_CPL_UPD;
         end
         S_CPL_UPD: begin
            if (pend_rd != '0) begin
               pend_we = 1'b1;
               pend_wa = dsel_ff;
               pend_wd = pend_rd - 1'b1;
               if (pend_rd == PEND_W'(1) && ntot_ff < CNT_W'(MAX_TASKS)) begin
                  wave_we    = 1'b1;
                  wave_wa    = {~bank_ff, ntot_ff[ID_W-1:0]};
                  wave_wd    = dsel_ff;
                  ntot_in    = ntot_ff + 1'b1;
                  res_new_in = res_new_ff + 1'b1;
               end
            end
            li_in = li_ff + 1'b1;
            if (DW'(li_ff + 1'b1) == cnt_ff) begin
               state_in = S_EMIT;
            end else begin
               list_ra  = LA_W'(done_ff) * LA_W'(MAX_DEPENDENTS) + LA_W'(li_ff + 1'b1);
               state_in = S_CPL_PND;
            end
         end
         S_EMIT: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tt_ff        <= '0;
         rtot_ff      <= '0;
         ptr_ff       <= '0;
         ntot_ff      <= '0;
         outs_ff      <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tt_ff    <= tt_in;
         rtot_ff  <= rtot_in;
         ptr_ff   <= ptr_in;
         ntot_ff  <= ntot_in;
         outs_ff  <= outs_in;
         bank_ff  <= bank_in;
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      dep_bad_ff  <= dep_bad_in;
      pay_ff      <= pay_in;
      n_ff        <= n_in;
      dep_ff      <= dep_in;
      done_ff     <= done_in;
      di_ff       <= di_in;
      li_ff       <= li_in;
      cnt_ff      <= cnt_in;
      tot_ff      <= tot_in;
      dsel_ff     <= dsel_in;
      res_st_ff   <= res_st_in;
      res_id_ff   <= res_id_in;
      res_pay_ff  <= res_pay_in;
      res_went_ff <= res_went_in;
      res_new_ff  <= res_new_in;
      if (rsp_load) begin
         rsp_status_ff <= res_st_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_pay_ff    <= res_pay_ff;
         rsp_went_ff   <= res_went_ff;
         rsp_new_ff    <= res_new_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_task_id     = rsp_id_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_went_ready  = rsp_went_ff;
   assign rsp_newly_ready = rsp_new_ff;

endmodule
`default_nettype wire

// ===== src/task_dependency_scheduler.sv =====
// Top level of the task dependency scheduler: front queue plus execution engine.
// Depends on tds_pkg, tds_front and tds_engine.
//
// Usage: one request beat on the req_ channel is a submit, a dispatch request
// or a completion; every beat yields exactly one result beat on the rsp_
// channel, in order. Both channels use valid and ready.
// The front end holds up to two request beats, so requests are taken while
// the engine works or a result waits for the receiver.
// Each request occupies the engine from the cycle it leaves the queue up to and
// including the cycle that loads the output register. A beat answered at once
// (table full, bad dependency, wait, all done) passes the decode and emit steps
// only; a submit adds a check and a link step per prerequisite and a write step,
// a dispatch adds a wave read, an id step and a payload read, and a completion
// adds a count read and, per dependent (up to MAX_DEPENDENTS), a list read and
// a pending-count read-modify-write.
// The engine pops another queued beat only after loading the result of the current one.
// Reset clears all counts and the queue; the tables need no clearing pass.
// When the receiver stalls, the result register holds, the engine waits in
// its final step and the queue fills before req_ready falls.
`default_nettype none
module task_dependency_scheduler #(
   parameter int MAX_TASKS      = tds_pkg::DEF_MAX_TASKS,
   parameter int MAX_DEPS       = tds_pkg::DEF_MAX_DEPS,
   parameter int MAX_DEPENDENTS = tds_pkg::DEF_MAX_DEPENDENTS,
   parameter int PAYLOAD_WIDTH  = tds_pkg::DEF_PAYLOAD_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_type,
   input  wire logic [PAYLOAD_WIDTH-1:0]            req_task_payload,
   input  wire logic [tds_pkg::COUNT_W-1:0]         req_dep_count,
   input  wire logic [$clog2(MAX_TASKS)-1:0]        req_dep_task_0,
   input  wire logic [$clog2(MAX_TASKS)-1:0]        req_dep_task_1,
   input  wire logic [$clog2(MAX_TASKS)-1:0]        req_dep_task_2,
   input  wire logic [$clog2(MAX_TASKS)-1:0]        req_dep_task_3,
   input  wire logic [$clog2(MAX_TASKS)-1:0]        req_done_task_id,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [2:0]                               rsp_status,
   output logic [$clog2(MAX_TASKS)-1:0]             rsp_task_id,
   output logic [PAYLOAD_WIDTH-1:0]                 rsp_out_payload,
   output logic                                     rsp_went_ready,
   output logic [$clog2(MAX_DEPENDENTS+1)-1:0]      rsp_newly_ready
);
   import tds_pkg::*;

   localparam int ID_W = $clog2(MAX_TASKS);

   logic                     cmd_valid;
   logic                     cmd_pop;
   cmd_ctl_type              cmd_ctl;
   logic [PAYLOAD_WIDTH-1:0] cmd_payload;
   logic [COUNT_W-1:0]       cmd_count;
   logic [ID_W-1:0]          cmd_dep [DEP_SLOTS];
   logic [ID_W-1:0]          cmd_done;

   tds_front #(
      .MAX_TASKS     (MAX_TASKS),
      .MAX_DEPS      (MAX_DEPS),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_task_payload (req_task_payload),
      .req_dep_count    (req_dep_count),
      .req_dep_task_0   (req_dep_task_0),
      .req_dep_task_1   (req_dep_task_1),
      .req_dep_task_2   (req_dep_task_2),
      .req_dep_task_3   (req_dep_task_3),
      .req_done_task_id (req_done_task_id),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd_ctl          (cmd_ctl),
      .cmd_payload      (cmd_payload),
      .cmd_count        (cmd_count),
      .cmd_dep          (cmd_dep),
      .cmd_done         (cmd_done)
   );

   tds_engine #(
      .MAX_TASKS      (MAX_TASKS),
      .MAX_DEPENDENTS (MAX_DEPENDENTS),
      .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd_ctl         (cmd_ctl),
      .cmd_payload     (cmd_payload),
      .cmd_count       (cmd_count),
      .cmd_dep         (cmd_dep),
      .cmd_done        (cmd_done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_task_id     (rsp_task_id),
      .rsp_out_payload (rsp_out_payload),
      .rsp_went_ready  (rsp_went_ready),
      .rsp_newly_ready (rsp_newly_ready)
   );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for task_dependency_scheduler: directed and random request
// beats, an in-house scheduler predictor and an in-order result checker.
// Depends on tds_pkg and the task_dependency_scheduler RTL.
`timescale 1ns / 1ps
module tb_top;
   import tds_pkg::*;

   localparam int TASKS      = 64;
   localparam int DEPENDENTS = 8;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      status_type  status;
      logic [5:0]  id;
      logic [31:0] payload;
      logic        went;
      logic [3:0]  newly;
   } sched_result;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = OP_DISPATCH;
   logic [31:0] req_task_payload = '0;
   logic [2:0]  req_dep_count = '0;
   logic [5:0]  req_dep_task_0 = '0, req_dep_task_1 = '0, req_dep_task_2 = '0;
   logic [5:0]  req_dep_task_3 = '0, req_done_task_id = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_task_id;
   logic [31:0] rsp_out_payload;
   logic        rsp_went_ready;
   logic [3:0]  rsp_newly_ready;

   task_dependency_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_task_payload(req_task_payload), .req_dep_count(req_dep_count),
      .req_dep_task_0(req_dep_task_0), .req_dep_task_1(req_dep_task_1),
      .req_dep_task_2(req_dep_task_2), .req_dep_task_3(req_dep_task_3),
      .req_done_task_id(req_done_task_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_task_id(rsp_task_id), .rsp_out_payload(rsp_out_payload),
      .rsp_went_ready(rsp_went_ready), .rsp_newly_ready(rsp_newly_ready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted scheduler state.
   logic [31:0] stored_payload [TASKS];
   int          pending [TASKS];
   int          follower_total [TASKS];
   int          follower_list [TASKS*DEPENDENTS];
   int          current_wave [TASKS];
   int          coming_wave [TASKS];
   int          task_total, wave_total, wave_pointer, coming_total, running;

   sched_result expected_results [$];
   int          running_ids [$];
   int          mismatches = 0;
   int          beats_sent = 0;
   int          cycle_count = 0;
   bit          idling_on = 1'b1;
   int          rsp_stall_left = 0;
   status_type  last_status;

   task automatic predict_outcome(input logic [1:0] op, input logic [31:0] pay,
                                  input logic [2:0] n, input logic [5:0] d0,
                                  input logic [5:0] d1, input logic [5:0] d2,
                                  input logic [5:0] d3, input logic [5:0] done,
                                  output sched_result r);
      int dep [4];
      int extra, id, cnt, f;
      bit rejected;
      r = '{ST_ACCEPTED, 6'd0, 32'd0, 1'b0, 4'd0};
      dep = '{int'(d0), int'(d1), int'(d2), int'(d3)};
      rejected = 1'b0;
      case (op)
         OP_SUBMIT: begin
            if (task_total >= TASKS) begin
               r.status = ST_TABLE_FULL;
               rejected = 1'b1;
            end else if (n > 4) begin
               r.status = ST_BAD_DEP;
               rejected = 1'b1;
            end else begin
               for (int i = 0; i < n; i++)
                  if (dep[i] >= task_total) rejected = 1'b1;
               if (rejected) r.status = ST_BAD_DEP;
            end
            if (!rejected) begin
               for (int i = 0; i < n; i++) begin
                  extra = 1;
                  for (int j = 0; j < i; j++) if (dep[j] == dep[i]) extra++;
                  if (follower_total[dep[i]] + extra > DEPENDENTS) rejected = 1'b1;
               end
               if (rejected) r.status = ST_DEPS_FULL;
            end
            if (!rejected) begin
               id = task_total;
               task_total++;
               stored_payload[id] = pay;
               pending[id] = n;
               follower_total[id] = 0;
               for (int i = 0; i < n; i++) begin
                  follower_list[dep[i]*DEPENDENTS + follower_total[dep[i]]] = id;
                  follower_total[dep[i]]++;
               end
               r.id = 6'(id);
               if (n == 0 && wave_total < TASKS) begin
                  current_wave[wave_total] = id;
                  wave_total++;
                  r.went = 1'b1;
               end
            end
         end
         OP_DISPATCH: begin
            if (wave_pointer >= wave_total) begin
               if (running > 0) begin
                  r.status = ST_WAIT;
                  rejected = 1'b1;
               end else if (coming_total == 0) begin
                  task_total = 0;
                  wave_total = 0;
                  wave_pointer = 0;
                  running = 0;
                  r.status = ST_ALL_DONE;
                  rejected = 1'b1;
               end else begin
                  for (int i = 0; i < coming_total; i++) current_wave[i] = coming_wave[i];
                  wave_total = coming_total;
                  wave_pointer = 0;
                  coming_total = 0;
               end
            end
            if (!rejected) begin
               id = current_wave[wave_pointer % TASKS] % TASKS;
               wave_pointer++;
               running++;
               r.status = ST_DISPATCHED;
               r.id = 6'(id);
               r.payload = stored_payload[id];
            end
         end
         OP_COMPLETE: begin
            if (running == 0 || done >= task_total) begin
               r.status = ST_BAD_DEP;
            end else begin
               running--;
               cnt = follower_total[done];
               if (cnt > DEPENDENTS) cnt = DEPENDENTS;
               for (int i = 0; i < cnt; i++) begin
                  f = follower_list[done*DEPENDENTS + i] % TASKS;
                  if (pending[f] != 0) begin
                     pending[f]--;
                     if (pending[f] == 0 && coming_total < TASKS) begin
                        coming_wave[coming_total] = f;
                        coming_total++;
                        r.newly++;
                     end
                  end
               end
               r.id = done;
            end
         end
         default: r.status = ST_BAD_DEP;
      endcase
   endtask

   task automatic send_req(input logic [1:0] op, input logic [31:0] pay,
                           input logic [2:0] n, input logic [5:0] d0,
                           input logic [5:0] d1, input logic [5:0] d2,
                           input logic [5:0] d3, input logic [5:0] done);
      sched_result r;
      req_valid <= 1'b1;
      req_type <= op;
      req_task_payload <= pay;
      req_dep_count <= n;
      req_dep_task_0 <= d0;
      req_dep_task_1 <= d1;
      req_dep_task_2 <= d2;
      req_dep_task_3 <= d3;
      req_done_task_id <= done;
      do @(posedge clock); while (!req_ready);
      predict_outcome(op, pay, n, d0, d1, d2, d3, done, r);
      expected_results.push_back(r);
      if (r.status == ST_DISPATCHED) running_ids.push_back(r.id);
      if (r.status == ST_ALL_DONE) running_ids.delete();
      last_status = r.status;
      beats_sent++;
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic submit(input logic [31:0] pay, input logic [2:0] n,
                         input logic [5:0] d0, input logic [5:0] d1,
                         input logic [5:0] d2, input logic [5:0] d3);
      send_req(OP_SUBMIT, pay, n, d0, d1, d2, d3, 6'($urandom));
   endtask

   task automatic finish_next();
      int k;
      if (running_ids.size() == 0) begin
         send_req(OP_COMPLETE, $urandom, 3'($urandom), 6'($urandom), 6'($urandom),
                  6'($urandom), 6'($urandom), 6'($urandom));
      end else begin
         k = $urandom_range(0, running_ids.size() - 1);
         send_req(OP_COMPLETE, $urandom, 3'($urandom), 6'($urandom), 6'($urandom),
                  6'($urandom), 6'($urandom), 6'(running_ids[k]));
         running_ids.delete(k);
      end
   endtask

   // A pick of prerequisite that leans towards low ids so that lists fill up.
   function automatic logic [5:0] pick_dep();
      if (task_total == 0) return 6'($urandom);
      if ($urandom_range(0, 2) == 0) return 6'($urandom_range(0, (task_total - 1) % 3));
      return 6'($urandom_range(0, task_total - 1));
   endfunction

   task automatic random_step(inout int graph_size);
      int choice;
      logic [2:0] n;
      choice = $urandom_range(0, 99);
      if (task_total < graph_size && choice < 60) begin
         if (choice < 2) n = 3'($urandom_range(5, 7));
         else n = 3'($urandom_range(0, 4));
         if (choice == 2)
            submit($urandom, n, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
         else
            submit($urandom, n, pick_dep(), pick_dep(), pick_dep(), pick_dep());
      end else if (choice < 62) begin
         send_req(OP_INVALID, $urandom, 3'($urandom), 6'($urandom), 6'($urandom),
                  6'($urandom), 6'($urandom), 6'($urandom));
      end else if (choice < 66) begin
         submit($urandom, 3'($urandom_range(0, 4)), pick_dep(), pick_dep(),
                pick_dep(), pick_dep());
      end else if (choice < 84) begin
         send_req(OP_DISPATCH, $urandom, 3'($urandom), 6'($urandom), 6'($urandom),
                  6'($urandom), 6'($urandom), 6'($urandom));
      end else begin
         finish_next();
      end
      if (last_status == ST_ALL_DONE)
         graph_size = ($urandom_range(0, 5) == 0) ? 70 : $urandom_range(1, 20);
   endtask

   task automatic test_empty_and_illegal();
      send_req(OP_DISPATCH, '0, '0, '0, '0, '0, '0, '0);
      send_req(OP_COMPLETE, '0, '0, '0, '0, '0, '0, '0);
      send_req(OP_INVALID, '1, '1, '1, '1, '1, '1, '1);
      submit(32'hFFFF_FFFF, 3'd5, 6'd0, 6'd0, 6'd0, 6'd0);
      submit(32'h0, 3'd7, 6'd63, 6'd63, 6'd63, 6'd63);
      submit(32'h0, 3'd1, 6'd0, 6'd0, 6'd0, 6'd0);
   endtask

   task automatic test_dependency_chain();
      submit(32'hFFFF_FFFF, 3'd0, '0, '0, '0, '0);
      submit(32'h0000_0000, 3'd1, 6'd0, '0, '0, '0);
      submit(32'hA5A5_5A5A, 3'd4, 6'd0, 6'd1, 6'd1, 6'd0);
      submit(32'h1234_5678, 3'd1, 6'd3, '0, '0, '0);
      submit(32'h0, 3'd1, 6'd1, '0, '0, '0);
      send_req(OP_DISPATCH, '0, '0, '0, '0, '0, '0, '0);
      send_req(OP_DISPATCH, '0, '0, '0, '0, '0, '0, '0);
      send_req(OP_COMPLETE, '0, '0, '0, '0, '0, '0, 6'd63);
      send_req(OP_COMPLETE, '0, '0, '0, '0, '0, '0, 6'd0);
      send_req(OP_COMPLETE, '0, '0, '0, '0, '0, '0, 6'd0);
      while (last_status != ST_ALL_DONE) begin
         send_req(OP_DISPATCH, '0, '0, '0, '0, '0, '0, '0);
         if (last_status == ST_DISPATCHED || last_status == ST_WAIT) finish_next();
      end
   endtask

   task automatic test_dependents_overflow();
      submit(32'h0, 3'd0, '0, '0, '0, '0);
      submit(32'h1, 3'd4, 6'd0, 6'd0, 6'd0, 6'd0);
      submit(32'h2, 3'd3, 6'd0, 6'd0, 6'd0, 6'd1);
      submit(32'h3, 3'd2, 6'd0, 6'd0, '0, '0);
      submit(32'h4, 3'd1, 6'd0, '0, '0, '0);
      submit(32'h5, 3'd1, 6'd0, '0, '0, '0);
   endtask

   task automatic test_random_graphs(input int beats, input bit with_idling);
      int graph_size;
      graph_size = 70;
      idling_on = with_idling;
      repeat (beats) random_step(graph_size);
   endtask

   always @(posedge clock) begin
      if (idling_on && rsp_stall_left == 0 && $urandom_range(0, 7) == 0)
         rsp_stall_left = $urandom_range(1, 18);
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sched_result e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat, status %0d", rsp_status);
         end else begin
            e = expected_results.pop_front();
            if (rsp_status !== e.status || rsp_task_id !== e.id ||
                rsp_out_payload !== e.payload || rsp_went_ready !== e.went ||
                rsp_newly_ready !== e.newly) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                           e.status, e.id, e.payload, e.went, e.newly, rsp_status,
                           rsp_task_id, rsp_out_payload, rsp_went_ready, rsp_newly_ready);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      task_total = 0;
      wave_total = 0;
      wave_pointer = 0;
      coming_total = 0;
      running = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_illegal();
      test_dependency_chain();
      test_dependents_overflow();
      test_random_graphs(800, 1'b1);
      test_random_graphs(150, 1'b0);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== task_dependency_scheduler.f =====
src/tds_pkg.sv
src/tds_front.sv
src/tds_engine.sv
src/task_dependency_scheduler.sv
tb/tb_top.sv
